/* rtl/srt_pkg.sv */
// ----------------------------------------------------------------------------
// srt_pkg
// Shared widths and codes for the surface ring table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package srt_pkg;

  localparam int MODE_W   = 3;
  localparam int TAG_IN_W = 32;
  localparam int SLOT_W   = 7;
  localparam int AGE_W    = 2;

  localparam logic [MODE_W-1:0] MODE_REG   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_UNREG = 3'd1;
  localparam logic [MODE_W-1:0] MODE_MARK  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_AGE   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_LOOK  = 3'd4;

  localparam logic [AGE_W-1:0] AGE_IDLE = 2'd0;
  localparam logic [AGE_W-1:0] AGE_LAST = 2'd1;
  localparam logic [AGE_W-1:0] AGE_CUR  = 2'd2;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

endpackage

`default_nettype wire

/* rtl/srt_if.sv */
// ----------------------------------------------------------------------------
// srt_in_if / srt_out_if
// Valid/ready channels for request and result beats.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface srt_in_if;
  import srt_pkg::*;
  logic                valid;
  logic                ready;
  logic [MODE_W-1:0]   mode;
  logic [TAG_IN_W-1:0] surface_tag;
  logic                with_dpb;
  modport source (output valid, mode, surface_tag, with_dpb, input ready);
  modport sink   (input valid, mode, surface_tag, with_dpb, output ready);
endinterface

interface srt_out_if;
  import srt_pkg::*;
  logic              valid;
  logic              ready;
  logic              status;
  logic              found;
  logic [SLOT_W-1:0] slot_index;
  modport source (output valid, status, found, slot_index, input ready);
  modport sink   (input valid, status, found, slot_index, output ready);
endinterface

`default_nettype wire

/* rtl/surface_ring_table_with_aging_evict_top.sv */
// ----------------------------------------------------------------------------
// surface_ring_table_with_aging_evict_top
// Ring of surface tags with age flags, eviction and compaction.
// ----------------------------------------------------------------------------
// Lookup/mark/unregister/register scan the ring, one entry a cycle; a
//   full-ring register adds an eviction scan and a compaction.
// End-frame ageing sweeps every slot. One beat at a time.
// Throughput is set by the single read and write port of the entry memory.
// After reset a clearing pass over every slot runs before the first beat.
`timescale 1ns / 1ps
`default_nettype none

module surface_ring_table_with_aging_evict_top #(
  parameter int RING_DEPTH = 128,
  parameter int TAG_BITS   = 32
) (
  input  wire        clk,
  input  wire        rst_n,
  srt_in_if.sink     in_ch,
  srt_out_if.source  out_ch
);
  import srt_pkg::*;

  localparam int AW = $clog2(RING_DEPTH);
  localparam int CW = $clog2(RING_DEPTH + 1);
  localparam int CB = (TAG_BITS < TAG_IN_W) ? TAG_BITS : TAG_IN_W;
  localparam int SB = (AW < SLOT_W) ? AW : SLOT_W;
  localparam logic [AW-1:0] LAST  = AW'(RING_DEPTH - 1);
  localparam logic [CW-1:0] DEPTH = CW'(RING_DEPTH);

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_SRCH = 4'd2;
  localparam logic [3:0] S_EVSC = 4'd3;
  localparam logic [3:0] S_MOVE = 4'd4;
  localparam logic [3:0] S_INS  = 4'd5;
  localparam logic [3:0] S_AGE  = 4'd6;
  localparam logic [3:0] S_RESP = 4'd7;

  typedef struct packed {
    logic [TAG_BITS-1:0] tag;
    logic [AGE_W-1:0]    age;
  } ent_t;

  function automatic logic [AW-1:0] ring_inc(input logic [AW-1:0] p);
    ring_inc = (p == LAST) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [AW-1:0] ring_dec(input logic [AW-1:0] p);
    ring_dec = (p == '0) ? LAST : p - 1'b1;
  endfunction

  ent_t mem [RING_DEPTH];
  ent_t rd_q;
  logic mem_we, mem_re;
  logic [AW-1:0] mem_wa, mem_ra;
  ent_t mem_wd;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rd_q <= mem[mem_ra];
  end

  logic [3:0]          state_r, state_nxt;
  logic [AW-1:0]       head_r, head_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic [MODE_W-1:0]   mode_r;
  logic [TAG_BITS-1:0] tag_r;
  logic [CW-1:0]       iss_r, iss_nxt;
  logic [AW-1:0]       addr_r, addr_nxt;
  logic                pend_r;
  logic [CW-1:0]       pend_age_r, pend_age_nxt;
  logic [AW-1:0]       pend_slot_r, pend_slot_nxt;
  logic [AW-1:0]       mv_dst_r, mv_dst_nxt, mv_src_r, mv_src_nxt;
  logic [CW-1:0]       mv_left_r, mv_left_nxt;
  logic                mv_up_r, mv_up_nxt;
  logic                res_st_r, res_st_nxt, res_fd_r, res_fd_nxt;
  logic [AW-1:0]       res_sl_r, res_sl_nxt;
  logic                out_valid_r;
  logic                out_status_r, out_found_r;
  logic [SLOT_W-1:0]   out_slot_r;

  logic [TAG_BITS-1:0] tag_w;
  logic                in_acc, out_free, rm_up;
  logic [CW-1:0]       half_c;

  assign tag_w    = TAG_BITS'(in_ch.surface_tag[CB-1:0]);
  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc   = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;
  assign half_c   = count_r >> 1;
  assign rm_up    = pend_age_r < half_c;

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    count_nxt     = count_r;
    iss_nxt       = iss_r;
    addr_nxt      = addr_r;
    pend_age_nxt  = pend_age_r;
    pend_slot_nxt = pend_slot_r;
    mv_dst_nxt    = mv_dst_r;
    mv_src_nxt    = mv_src_r;
    mv_left_nxt   = mv_left_r;
    mv_up_nxt     = mv_up_r;
    res_st_nxt    = res_st_r;
    res_fd_nxt    = res_fd_r;
    res_sl_nxt    = res_sl_r;
    mem_we = 1'b0;
    mem_wa = addr_r;
    mem_wd = '0;
    mem_re = 1'b0;
    mem_ra = addr_r;

    unique case (state_r)
      S_CLR: begin
        mem_we   = 1'b1;
        addr_nxt = ring_inc(addr_r);
        if (addr_r == LAST) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        res_st_nxt = STATUS_ERR;
        res_fd_nxt = 1'b0;
        res_sl_nxt = '0;
        iss_nxt    = '0;
        addr_nxt   = ring_dec(head_r);
        if (in_acc) begin
          case (in_ch.mode)
            MODE_AGE: begin
              addr_nxt  = '0;
              state_nxt = S_AGE;
            end
            MODE_REG, MODE_UNREG, MODE_MARK, MODE_LOOK: begin
              if (tag_w == '0) state_nxt = S_RESP;
              else state_nxt = S_SRCH;
            end
            default: state_nxt = S_RESP;
          endcase
        end
      end
      S_SRCH: begin
        if (pend_r && rd_q.tag == tag_r) begin
          res_st_nxt = STATUS_OK;
          state_nxt  = S_RESP;
          case (mode_r)
            MODE_UNREG: begin
              mv_up_nxt   = rm_up;
              mv_dst_nxt  = pend_slot_r;
              mv_src_nxt  = rm_up ? ring_inc(pend_slot_r) : ring_dec(pend_slot_r);
              mv_left_nxt = rm_up ? pend_age_r : count_r - 1'b1 - pend_age_r;
              state_nxt   = S_MOVE;
            end
            MODE_MARK: begin
              mem_we = 1'b1;
              mem_wa = pend_slot_r;
              mem_wd = '{tag: tag_r, age: AGE_CUR};
            end
            MODE_LOOK: begin
              res_fd_nxt = 1'b1;
              res_sl_nxt = pend_slot_r;
            end
            default: ;
          endcase
        end else if (iss_r < count_r) begin
          mem_re        = 1'b1;
          pend_age_nxt  = iss_r;
          pend_slot_nxt = addr_r;
          addr_nxt      = ring_dec(addr_r);
          iss_nxt       = iss_r + 1'b1;
        end else if (!pend_r) begin
          iss_nxt  = '0;
          addr_nxt = head_r;
          if (mode_r != MODE_REG) state_nxt = S_RESP;
          else if (count_r < DEPTH) state_nxt = S_INS;
          else state_nxt = S_EVSC;
        end
      end
      S_EVSC: begin
        if (pend_r && rd_q.age == AGE_IDLE) begin
          mv_up_nxt   = rm_up;
          mv_dst_nxt  = pend_slot_r;
          mv_src_nxt  = rm_up ? ring_inc(pend_slot_r) : ring_dec(pend_slot_r);
          mv_left_nxt = rm_up ? pend_age_r : count_r - 1'b1 - pend_age_r;
          state_nxt   = S_MOVE;
        end else if (iss_r < count_r) begin
          mem_re        = 1'b1;
          pend_age_nxt  = count_r - 1'b1 - iss_r;
          pend_slot_nxt = addr_r;
          addr_nxt      = ring_inc(addr_r);
          iss_nxt       = iss_r + 1'b1;
        end else if (!pend_r) begin
          state_nxt = S_RESP;
        end
      end
      S_MOVE: begin
        if (pend_r) begin
          mem_we     = 1'b1;
          mem_wa     = mv_dst_r;
          mem_wd     = rd_q;
          mv_dst_nxt = mv_up_r ? ring_inc(mv_dst_r) : ring_dec(mv_dst_r);
        end
        if (mv_left_r != '0) begin
          mem_re      = 1'b1;
          mem_ra      = mv_src_r;
          mv_src_nxt  = mv_up_r ? ring_inc(mv_src_r) : ring_dec(mv_src_r);
          mv_left_nxt = mv_left_r - 1'b1;
        end else if (!pend_r) begin
          mem_we    = 1'b1;
          mem_wa    = mv_dst_r;
          mem_wd    = '0;
          count_nxt = count_r - 1'b1;
          if (mv_up_r) head_nxt = ring_dec(head_r);
          res_st_nxt = STATUS_OK;
          state_nxt  = (mode_r == MODE_REG) ? S_INS : S_RESP;
        end
      end
      S_INS: begin
        mem_we     = 1'b1;
        mem_wa     = head_r;
        mem_wd     = '{tag: tag_r, age: AGE_CUR};
        head_nxt   = ring_inc(head_r);
        count_nxt  = count_r + 1'b1;
        res_st_nxt = STATUS_OK;
        state_nxt  = S_RESP;
      end
      S_AGE: begin
        if (pend_r) begin
          mem_we = 1'b1;
          mem_wa = pend_slot_r;
          mem_wd = '{tag: rd_q.tag,
                     age: (rd_q.age == AGE_IDLE) ? AGE_IDLE : rd_q.age - 1'b1};
        end
        if (iss_r < DEPTH) begin
          mem_re        = 1'b1;
          pend_slot_nxt = addr_r;
          addr_nxt      = ring_inc(addr_r);
          iss_nxt       = iss_r + 1'b1;
        end else if (!pend_r) begin
          res_st_nxt = STATUS_OK;
          state_nxt  = S_RESP;
        end
      end
      S_RESP: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      head_r      <= '0;
      count_r     <= '0;
      addr_r      <= '0;
      iss_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      count_r <= count_nxt;
      addr_r  <= addr_nxt;
      iss_r   <= iss_nxt;
      pend_r  <= mem_re;
      if (state_r == S_RESP && out_free) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    pend_age_r  <= pend_age_nxt;
    pend_slot_r <= pend_slot_nxt;
    mv_dst_r    <= mv_dst_nxt;
    mv_src_r    <= mv_src_nxt;
    mv_left_r   <= mv_left_nxt;
    mv_up_r     <= mv_up_nxt;
    res_st_r    <= res_st_nxt;
    res_fd_r    <= res_fd_nxt;
    res_sl_r    <= res_sl_nxt;
    if (in_acc) begin
      mode_r <= in_ch.mode;
      tag_r  <= tag_w;
    end
    if (state_r == S_RESP && out_free) begin
      out_status_r <= res_st_r;
      out_found_r  <= res_fd_r;
      out_slot_r   <= SLOT_W'(res_sl_r[SB-1:0]);
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.status     = out_status_r;
  assign out_ch.found      = out_found_r;
  assign out_ch.slot_index = out_slot_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= DEPTH) else $error("entry count beyond ring depth");

  a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !mem_we) else $error("memory write while idle");

  a_age_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_ch.mode == MODE_AGE) |=> (state_r == S_AGE))
    else $error("end-frame beat did not start ageing sweep");

endmodule

`default_nettype wire

/* dv/tb_surface_ring_table_with_aging_evict_top.sv */
// ----------------------------------------------------------------------------
// tb_surface_ring_table_with_aging_evict_top
// Drives register, unregister, mark, ageing and lookup beats into the surface
// ring table and checks every result against an in-bench model of the ring,
// including eviction on a full ring and compaction of whichever side is shorter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tb_surface_ring_table_with_aging_evict_top;
  import srt_pkg::*;

  localparam int DEPTH = 128;

  typedef struct packed {
    logic              status;
    logic              found;
    logic [SLOT_W-1:0] slot_index;
  } result_t;

  typedef logic bool_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #6 clk = ~clk;

  srt_in_if  in_ch ();
  srt_out_if out_ch ();

  surface_ring_table_with_aging_evict_top i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  logic [TAG_IN_W-1:0] ring_tag [DEPTH];
  logic [AGE_W-1:0]    ring_age [DEPTH];
  int                  head_slot;
  int                  n_entries;
  result_t             pending_q[$];
  int                  n_errors;
  logic [TAG_IN_W-1:0] pool [16];

  initial begin
    in_ch.valid       = 1'b0;
    in_ch.mode        = MODE_REG;
    in_ch.surface_tag = '0;
    in_ch.with_dpb    = 1'b0;
    out_ch.ready      = 1'b0;
  end

  function automatic int slot_at(int age);
    return (head_slot + 2 * DEPTH - 1 - age) % DEPTH;
  endfunction

  function automatic void swap_slots(int a, int b);
    logic [TAG_IN_W-1:0] t;
    logic [AGE_W-1:0]    f;
    t = ring_tag[a]; f = ring_age[a];
    ring_tag[a] = ring_tag[b]; ring_age[a] = ring_age[b];
    ring_tag[b] = t; ring_age[b] = f;
  endfunction

  function automatic void drop_entry(int age);
    int cur;
    int nb;
    cur = slot_at(age);
    ring_tag[cur] = '0;
    ring_age[cur] = AGE_IDLE;
    if (age < n_entries / 2) begin
      for (int i = 0; i < age; i++) begin
        nb = (cur + 1) % DEPTH;
        swap_slots(cur, nb);
        cur = nb;
      end
      head_slot = (head_slot + DEPTH - 1) % DEPTH;
    end else begin
      for (int i = 0; i + age + 1 < n_entries; i++) begin
        nb = (cur + DEPTH - 1) % DEPTH;
        swap_slots(cur, nb);
        cur = nb;
      end
    end
    n_entries--;
  endfunction

  function automatic int age_of_tag(logic [TAG_IN_W-1:0] tag);
    for (int i = 0; i < n_entries; i++)
      if (ring_tag[slot_at(i)] == tag) return i;
    return -1;
  endfunction

  function automatic int slot_of_tag(logic [TAG_IN_W-1:0] tag);
    for (int i = 0; i < DEPTH; i++)
      if (ring_tag[i] == tag) return i;
    return -1;
  endfunction

  function automatic result_t predict_ring(logic [MODE_W-1:0] mode,
                                           logic [TAG_IN_W-1:0] tag, logic dpb);
    result_t r;
    int      k;
    bool_t   done;
    r = '{status: STATUS_ERR, found: 1'b0, slot_index: '0};
    case (mode)
      MODE_REG: if (tag != 0) begin
        if (age_of_tag(tag) >= 0) r.status = STATUS_OK;
        else begin
          done = 1'b1;
          if (n_entries >= DEPTH) begin
            done = 1'b0;
            for (int i = n_entries; i > 0; i--)
              if (ring_age[slot_at(i - 1)] == AGE_IDLE) begin
                drop_entry(i - 1);
                done = 1'b1;
                break;
              end
          end
          if (done) begin
            ring_tag[head_slot] = tag;
            ring_age[head_slot] = AGE_CUR;
            n_entries++;
            head_slot = (head_slot + 1) % DEPTH;
            r.status = STATUS_OK;
          end
        end
      end
      MODE_UNREG: if (tag != 0) begin
        k = age_of_tag(tag);
        if (k >= 0) begin
          drop_entry(k);
          r.status = STATUS_OK;
        end
      end
      MODE_MARK: if (tag != 0) begin
        k = slot_of_tag(tag);
        if (k >= 0) begin
          ring_age[k] = AGE_CUR;
          r.status = STATUS_OK;
        end
      end
      MODE_AGE: begin
        for (int i = 0; i < DEPTH; i++) begin
          if (dpb) begin
            if (ring_age[i] == AGE_LAST) ring_age[i] = AGE_IDLE;
            else if (ring_age[i] == AGE_CUR) ring_age[i] = AGE_LAST;
          end else if (ring_age[i] != AGE_IDLE) begin
            ring_age[i] = ring_age[i] - 1'b1;
          end
        end
        r.status = STATUS_OK;
      end
      MODE_LOOK: if (tag != 0 && n_entries != 0) begin
        k = slot_of_tag(tag);
        if (k >= 0) begin
          r.status = STATUS_OK;
          r.found = 1'b1;
          r.slot_index = k[SLOT_W-1:0];
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("ERROR %s: got %0d want %0d", what, got, want);
    n_errors++;
  endtask

  // sender: bursts with random gaps
  int burst_left = 0;

  task automatic send_beat(logic [MODE_W-1:0] mode, logic [TAG_IN_W-1:0] tag,
                           logic dpb);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if ($urandom_range(0, 2) != 0) begin
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
    burst_left--;
    in_ch.valid       <= 1'b1;
    in_ch.mode        <= mode;
    in_ch.surface_tag <= tag;
    in_ch.with_dpb    <= dpb;
    pending_q.push_back(predict_ring(mode, tag, dpb));
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // receiver stall pattern
  int stall_phase = 0;
  always @(posedge clk) begin
    stall_phase <= stall_phase + 1;
    if (stall_phase % 400 < 150) out_ch.ready <= 1'b1;
    else out_ch.ready <= ($urandom_range(0, 3) != 0);
  end

  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_q.size() == 0) report_mismatch("unexpected beat", 1, 0);
      else begin
        want = pending_q.pop_front();
        if (out_ch.status !== want.status)
          report_mismatch("status", out_ch.status, want.status);
        if (out_ch.found !== want.found)
          report_mismatch("found", out_ch.found, want.found);
        if (out_ch.slot_index !== want.slot_index)
          report_mismatch("slot_index", out_ch.slot_index, want.slot_index);
      end
    end
  end

  task automatic drain_results;
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_q.size() != 0);
  endtask

  function automatic logic [TAG_IN_W-1:0] pick_tag();
    if ($urandom_range(0, 19) == 0) return '0;
    if ($urandom_range(0, 3) == 0) return $urandom;
    return pool[$urandom_range(0, 15)];
  endfunction

  task automatic test_directed;
    send_beat(MODE_LOOK, 32'h1, 1'b0);
    send_beat(MODE_REG, 32'h0, 1'b0);
    send_beat(MODE_UNREG, 32'h0, 1'b0);
    send_beat(MODE_MARK, 32'h0, 1'b0);
    send_beat(MODE_LOOK, 32'h0, 1'b0);
    send_beat(MODE_REG, 32'hFFFF_FFFF, 1'b0);
    send_beat(MODE_REG, 32'h1, 1'b0);
    send_beat(MODE_REG, 32'h1, 1'b0);
    send_beat(MODE_LOOK, 32'hFFFF_FFFF, 1'b0);
    send_beat(MODE_LOOK, 32'h5555_AAAA, 1'b0);
    send_beat(MODE_UNREG, 32'h5555_AAAA, 1'b0);
    send_beat(MODE_MARK, 32'hAAAA_5555, 1'b0);
    send_beat(MODE_AGE, 32'h0, 1'b1);
    send_beat(MODE_MARK, 32'h1, 1'b0);
    send_beat(MODE_AGE, 32'h0, 1'b0);
    send_beat(MODE_AGE, 32'h0, 1'b1);
    send_beat(3'd5, 32'h1, 1'b0);
    send_beat(3'd6, 32'h1, 1'b1);
    send_beat(3'd7, 32'hFFFF_FFFF, 1'b1);
    send_beat(MODE_UNREG, 32'hFFFF_FFFF, 1'b0);
    send_beat(MODE_LOOK, 32'h1, 1'b0);
  endtask

  // fill the ring, overflow with all current, then evict after ageing
  task automatic test_full_ring;
    for (int i = 0; i < DEPTH + 2; i++) send_beat(MODE_REG, 32'h100 + i, 1'b0);
    drain_results();
    send_beat(MODE_AGE, 32'h0, 1'b0);
    send_beat(MODE_AGE, 32'h0, 1'b1);
    for (int i = 0; i < 20; i++) send_beat(MODE_MARK, 32'h100 + $urandom_range(0, 127), 1'b0);
    for (int i = 0; i < 24; i++) send_beat(MODE_REG, 32'h800 + i, 1'b0);
    for (int i = 0; i < 12; i++) send_beat(MODE_UNREG, 32'h100 + $urandom_range(0, 127), 1'b0);
    send_beat(MODE_LOOK, 32'h810, 1'b0);
  endtask

  task automatic test_random;
    logic [MODE_W-1:0] m;
    int                r;
    for (int i = 0; i < 16; i++) pool[i] = $urandom | 32'h1;
    for (int i = 0; i < 420; i++) begin
      r = $urandom_range(0, 99);
      if (r < 35) m = MODE_REG;
      else if (r < 55) m = MODE_UNREG;
      else if (r < 70) m = MODE_MARK;
      else if (r < 80) m = MODE_AGE;
      else if (r < 97) m = MODE_LOOK;
      else m = 3'($urandom_range(5, 7));
      send_beat(m, pick_tag(), 1'($urandom));
      if (i == 200) drain_results();
    end
  endtask

  initial begin
    n_errors = 0;
    head_slot = 0;
    n_entries = 0;
    for (int i = 0; i < DEPTH; i++) begin
      ring_tag[i] = '0;
      ring_age[i] = AGE_IDLE;
    end
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_full_ring();
    test_random();
    drain_results();
    repeat (2 * DEPTH + 20) @(posedge clk);
    if (n_errors == 0) $display("surface_ring_table_with_aging_evict_top: match");
    else $display("surface_ring_table_with_aging_evict_top: mismatch");
    $finish;
  end

  initial begin
    #20ms;
    $display("surface_ring_table_with_aging_evict_top: mismatch");
    $finish;
  end

endmodule

`default_nettype wire
